>>> rtl/fbtt_pkg.sv
// Package for the foreground box track table: constants, payload types, states.
package fbtt_pkg;

   localparam int MaxTracks = 32;
   localparam int MaxBoxes  = 32;
   localparam int CoordBits = 12;

   localparam int AreaBits = 25;
   localparam int SideBits = 13;
   localparam int PermBits = 10;
   localparam int CntBits  = 6;
   localparam int SumBits  = 30;

   localparam logic [CntBits-1:0] CountMax = {CntBits{1'b1}};
   localparam logic [SumBits-1:0] SumMax   = {SumBits{1'b1}};
   localparam logic [9:0]         PerMille = 10'd1000;

   localparam logic [2:0] CsrMinArea   = 3'd0;
   localparam logic [2:0] CsrMinSide   = 3'd1;
   localparam logic [2:0] CsrOverlap   = 3'd2;
   localparam logic [2:0] CsrMissLimit = 3'd3;
   localparam logic [2:0] CsrRetire    = 3'd4;
   localparam logic [2:0] CsrStable    = 3'd5;
   localparam logic [2:0] CsrStableMin = 3'd6;

   typedef struct packed {
      logic [11:0] box_x;
      logic [11:0] box_y;
      logic [12:0] box_w;
      logic [12:0] box_h;
      logic [24:0] contour_area;
      logic        box_present;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic [11:0] stable_x;
      logic [11:0] stable_y;
      logic [12:0] stable_w;
      logic [12:0] stable_h;
      logic        stable_valid;
      logic [29:0] fore_area_sum;
      logic        boxes_dropped;
      logic        last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_TRK_RD,
      ST_BOX_RD,
      ST_CMP1,
      ST_CMP2,
      ST_TRK_WR,
      ST_NEW_RD,
      ST_NEW_WR,
      ST_EMIT_RD,
      ST_EMIT_CHK,
      ST_EMIT_OUT,
      ST_DONE
   } state_type;

endpackage

>>> rtl/foreground_box_track_table_unit.sv
// Top level of the foreground box track table.
//
// The block takes foreground boxes on the req_ channel, one item per box, and
// keeps those that pass the area and side filters in a frame buffer memory.
// The item that carries frame_end starts the table update: the track memory is
// walked in order, each track is compared against the unclaimed boxes of the
// frame one at a time, and the table is compacted in place as it goes. Boxes
// left unclaimed are then appended as new tracks; if the table was not empty
// at frame end, a final walk sends every stable track on the rsp_ channel,
// one item each, the last of the frame marked by last_result. A frame without
// stable tracks gives one item with stable_valid low.
// An item without frame_end is taken while the block stays idle, so such items
// can follow back to back. A frame-end item walks the box buffer through its
// one read port in the compare loop for each track.
// When the receiver stalls, the block holds its result in the output register
// and waits; no new item is accepted until the frame's last result is loaded.
// Reset empties the track table and the frame buffer through their counts;
// configuration registers return to their default values. The csr_ channel
// is always ready.
module foreground_box_track_table_unit
   import fbtt_pkg::*;
#(
   parameter int MAX_TRACKS = MaxTracks,
   parameter int MAX_BOXES  = MaxBoxes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int TA = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int BA = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int TC = $clog2(MAX_TRACKS + 1);
   localparam int BC = $clog2(MAX_BOXES + 1);
   localparam int BoxBits = 2 * CoordBits + 2 * (CoordBits + 1);
   localparam int TrkBits = BoxBits + 2 * CntBits;
   localparam int EB = CoordBits + 1;

   // Configuration registers.
   logic [AreaBits-1:0] min_area_ff, stable_min_ff;
   logic [SideBits-1:0] min_side_ff;
   logic [PermBits-1:0] overlap_ff;
   logic [CntBits-1:0]  miss_limit_ff, retire_ff, stable_cnt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff   <= AreaBits'(100);
         min_side_ff   <= SideBits'(15);
         overlap_ff    <= PermBits'(950);
         miss_limit_ff <= CntBits'(10);
         retire_ff     <= CntBits'(20);
         stable_cnt_ff <= CntBits'(40);
         stable_min_ff <= AreaBits'(250);
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrMinArea:   min_area_ff   <= csr_data[AreaBits-1:0];
            CsrMinSide:   min_side_ff   <= csr_data[SideBits-1:0];
            CsrOverlap:   overlap_ff    <= csr_data[PermBits-1:0];
            CsrMissLimit: miss_limit_ff <= csr_data[CntBits-1:0];
            CsrRetire:    retire_ff     <= csr_data[CntBits-1:0];
            CsrStable:    stable_cnt_ff <= csr_data[CntBits-1:0];
            CsrStableMin: stable_min_ff <= csr_data[AreaBits-1:0];
            default: ;
         endcase
      end
   end

   // Box fields: {x, y, w, h}.
   function automatic logic [CoordBits-1:0] bx(input logic [BoxBits-1:0] b);
      return b[BoxBits-1 -: CoordBits];
   endfunction
   function automatic logic [CoordBits-1:0] by(input logic [BoxBits-1:0] b);
      return b[BoxBits-1-CoordBits -: CoordBits];
   endfunction
   function automatic logic [CoordBits:0] bw(input logic [BoxBits-1:0] b);
      return b[2*(CoordBits+1)-1 -: CoordBits+1];
   endfunction
   function automatic logic [CoordBits:0] bh(input logic [BoxBits-1:0] b);
      return b[CoordBits:0];
   endfunction

   // Memories.
   logic               box_we;
   logic [BA-1:0]      box_wa, box_ra;
   logic [BoxBits-1:0] box_wd, box_rd;
   logic               trk_we;
   logic [TA-1:0]      trk_wa, trk_ra;
   logic [TrkBits-1:0] trk_wd, trk_rd;

   fbtt_ram #(.Width(BoxBits), .Depth(MAX_BOXES)) u_box_ram (
      .clock(clock), .wr_en(box_we), .wr_addr(box_wa), .wr_data(box_wd),
      .rd_addr(box_ra), .rd_data(box_rd));

   fbtt_ram #(.Width(TrkBits), .Depth(MAX_TRACKS)) u_trk_ram (
      .clock(clock), .wr_en(trk_we), .wr_addr(trk_wa), .wr_data(trk_wd),
      .rd_addr(trk_ra), .rd_data(trk_rd));

   // Control state.
   state_type           state_ff, state_in;
   logic [BC-1:0]       nbox_ff;
   logic [TC-1:0]       ntrk_ff, kept_ff, tidx_ff;
   logic [BC-1:0]       bidx_ff;
   logic [MAX_BOXES-1:0] claimed_ff;
   logic                ovf_ff, had_ff, matched_ff, any_ff;
   logic [SumBits-1:0]  sum_ff;
   logic [TrkBits-1:0]  cur_ff;
   logic [BoxBits-1:0]  cand_ff;
   logic [TC-1:0]       nsent_ff;
   logic                pend_ff;
   logic [BoxBits-1:0]  pend_box_ff;
   // The stable box found last, sent once the next one shows whether it is last.
   logic [BoxBits-1:0]  hold_box_ff;
   // Compare pipeline registers.
   logic [2*EB-1:0]     inter_ff;
   logic [2*EB-1:0]     uni_ff;
   logic                inter_ok_ff;
   rsp_type             rsp_ff;
   logic                rsp_vld_ff;

   logic [BoxBits-1:0] tbox;
   assign tbox = cur_ff[TrkBits-1 -: BoxBits];
   logic [CntBits-1:0] thits, tmiss;
   assign thits = cur_ff[2*CntBits-1 -: CntBits];
   assign tmiss = cur_ff[CntBits-1:0];

   // Intersection and union extents of track box and candidate box.
   logic [EB-1:0] ax1, bx1, ay1, by1, ix0, iy0, ix1, iy1, ux0, uy0, ux1, uy1;
   always_comb begin
      ax1 = EB'(bx(tbox)) + bw(tbox);
      bx1 = EB'(bx(box_rd)) + bw(box_rd);
      ay1 = EB'(by(tbox)) + bh(tbox);
      by1 = EB'(by(box_rd)) + bh(box_rd);
      ix0 = (bx(tbox) > bx(box_rd)) ? EB'(bx(tbox)) : EB'(bx(box_rd));
      iy0 = (by(tbox) > by(box_rd)) ? EB'(by(tbox)) : EB'(by(box_rd));
      ux0 = (bx(tbox) < bx(box_rd)) ? EB'(bx(tbox)) : EB'(bx(box_rd));
      uy0 = (by(tbox) < by(box_rd)) ? EB'(by(tbox)) : EB'(by(box_rd));
      ix1 = (ax1 < bx1) ? ax1 : bx1;
      iy1 = (ay1 < by1) ? ay1 : by1;
      ux1 = (ax1 > bx1) ? ax1 : bx1;
      uy1 = (ay1 > by1) ? ay1 : by1;
   end

   logic [2*EB+9:0] lhs, rhs;
   assign lhs = (2*EB+10)'(inter_ff) * (2*EB+10)'(PerMille);
   assign rhs = (2*EB+10)'(uni_ff) * (2*EB+10)'(overlap_ff);
   logic is_match;
   assign is_match = inter_ok_ff && (lhs > rhs);

   // Accept and filter logic.
   logic req_acc, box_keep;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc = req_valid && req_ready;
   assign box_keep = req_data.box_present && req_data.contour_area >= min_area_ff &&
                     req_data.box_w >= min_side_ff && req_data.box_h >= min_side_ff;

   logic [2*EB-1:0] wh_prod;
   assign wh_prod = bw(box_rd) * bh(box_rd);
   logic [SumBits:0] sum_add;
   assign sum_add = {1'b0, sum_ff} + (SumBits+1)'(wh_prod);

   logic [CntBits-1:0] new_hits, new_miss;
   assign new_hits = (thits == CountMax) ? thits : thits + 1'b1;
   assign new_miss = (tmiss == CountMax) ? tmiss : tmiss + 1'b1;

   logic emit_ok;
   assign emit_ok = (trk_rd[2*CntBits-1 -: CntBits] > stable_cnt_ff) &&
                    (2*EB)'(bw(trk_rd[TrkBits-1 -: BoxBits])) *
                    (2*EB)'(bh(trk_rd[TrkBits-1 -: BoxBits])) > (2*EB)'(stable_min_ff);

   // During the area sum the read address runs one box ahead of the data.
   logic last_box, rsp_free, rsp_send;
   assign last_box = bidx_ff >= nbox_ff;
   assign rsp_free = !rsp_vld_ff || rsp_ready;
   assign rsp_send = rsp_free && (((state_ff == ST_EMIT_OUT) && pend_ff && any_ff) ||
                                  (state_ff == ST_DONE));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_acc && req_data.frame_end) state_in = ST_SUM_RD;
         ST_SUM_RD:   state_in = (nbox_ff == '0) ? ST_TRK_RD : ST_SUM_ACC;
         ST_SUM_ACC:  state_in = last_box ? ST_TRK_RD : ST_SUM_ACC;
         ST_TRK_RD:   state_in = (tidx_ff >= ntrk_ff) ? ST_NEW_RD : ST_BOX_RD;
         ST_BOX_RD:   state_in = (bidx_ff >= nbox_ff) ? ST_TRK_WR :
                                 (claimed_ff[bidx_ff[BA-1:0]] ? ST_BOX_RD : ST_CMP1);
         ST_CMP1:     state_in = ST_CMP2;
         ST_CMP2:     state_in = is_match ? ST_TRK_WR : ST_BOX_RD;
         ST_TRK_WR:   state_in = ST_TRK_RD;
         ST_NEW_RD:   state_in = (bidx_ff >= nbox_ff) ? ST_EMIT_RD : ST_NEW_WR;
         ST_NEW_WR:   state_in = ST_NEW_RD;
         ST_EMIT_RD:  state_in = (!had_ff || tidx_ff >= ntrk_ff ||
                                  nsent_ff >= TC'(MAX_TRACKS)) ? ST_DONE : ST_EMIT_CHK;
         ST_EMIT_CHK: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: state_in = rsp_free ? ST_EMIT_RD : ST_EMIT_OUT;
         ST_DONE:     state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Memory port control.
   always_comb begin
      box_we = 1'b0;
      box_wa = nbox_ff[BA-1:0];
      box_wd = {req_data.box_x[CoordBits-1:0], req_data.box_y[CoordBits-1:0],
                req_data.box_w[CoordBits:0], req_data.box_h[CoordBits:0]};
      box_ra = bidx_ff[BA-1:0];
      trk_we = 1'b0;
      trk_wa = kept_ff[TA-1:0];
      trk_wd = cur_ff;
      trk_ra = tidx_ff[TA-1:0];
      unique case (state_ff)
         ST_IDLE: box_we = req_acc && box_keep && (nbox_ff < BC'(MAX_BOXES));
         ST_TRK_WR: begin
            trk_we = matched_ff ? (thits <= retire_ff) : (new_miss <= miss_limit_ff);
            trk_wd = matched_ff ? cur_ff : {tbox, thits, new_miss};
         end
         ST_NEW_WR: begin
            trk_we = !claimed_ff[bidx_ff[BA-1:0]] && (kept_ff < TC'(MAX_TRACKS));
            trk_wd = {box_rd, {2*CntBits{1'b0}}};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         nbox_ff    <= '0;
         ntrk_ff    <= '0;
         ovf_ff     <= 1'b0;
         claimed_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_send || (rsp_vld_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && box_keep) begin
                  if (nbox_ff < BC'(MAX_BOXES)) nbox_ff <= nbox_ff + 1'b1;
                  else ovf_ff <= 1'b1;
               end
               bidx_ff  <= '0;
               sum_ff   <= '0;
               claimed_ff <= '0;
            end
            ST_SUM_RD: begin
               bidx_ff <= bidx_ff + 1'b1;
               tidx_ff <= '0;
               kept_ff <= '0;
               had_ff  <= (ntrk_ff != '0);
            end
            ST_SUM_ACC: begin
               sum_ff  <= sum_add[SumBits] ? SumMax : sum_add[SumBits-1:0];
               bidx_ff <= last_box ? '0 : bidx_ff + 1'b1;
            end
            ST_TRK_RD: begin
               bidx_ff    <= '0;
               matched_ff <= 1'b0;
               if (tidx_ff >= ntrk_ff) ntrk_ff <= kept_ff;
            end
            ST_BOX_RD: begin
               // First cycle of a track: capture the track word.
               if (bidx_ff == '0 && !matched_ff) cur_ff <= trk_rd;
               if (claimed_ff[bidx_ff[BA-1:0]]) bidx_ff <= bidx_ff + 1'b1;
               matched_ff <= 1'b0;
            end
            ST_CMP1: begin
               cand_ff     <= box_rd;
               inter_ok_ff <= (ix1 > ix0) && (iy1 > iy0);
               inter_ff    <= (ix1 - ix0) * (iy1 - iy0);
               uni_ff      <= (ux1 - ux0) * (uy1 - uy0);
            end
            ST_CMP2: begin
               if (is_match) begin
                  claimed_ff[bidx_ff[BA-1:0]] <= 1'b1;
                  cur_ff     <= {cand_ff, new_hits, {CntBits{1'b0}}};
                  matched_ff <= 1'b1;
               end else begin
                  bidx_ff <= bidx_ff + 1'b1;
               end
            end
            ST_TRK_WR: begin
               if (trk_we) kept_ff <= kept_ff + 1'b1;
               tidx_ff <= tidx_ff + 1'b1;
               bidx_ff <= '0;
               matched_ff <= 1'b0;
            end
            ST_NEW_RD: begin
               tidx_ff  <= '0;
               nsent_ff <= '0;
               any_ff   <= 1'b0;
               pend_ff  <= 1'b0;
            end
            ST_NEW_WR: begin
               if (!claimed_ff[bidx_ff[BA-1:0]]) begin
                  if (kept_ff < TC'(MAX_TRACKS)) begin
                     kept_ff <= kept_ff + 1'b1;
                     ntrk_ff <= kept_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
               bidx_ff <= bidx_ff + 1'b1;
            end
            ST_EMIT_CHK: begin
               tidx_ff <= tidx_ff + 1'b1;
               if (emit_ok) begin
                  pend_ff     <= 1'b1;
                  pend_box_ff <= trk_rd[TrkBits-1 -: BoxBits];
               end
            end
            ST_EMIT_OUT: begin
               // A found stable track is held back one step so the last one
               // can be marked.
               if (rsp_free) begin
                  if (pend_ff && any_ff) begin
                     rsp_ff <= '{stable_x: 12'(bx(hold_box_ff)),
                                 stable_y: 12'(by(hold_box_ff)),
                                 stable_w: 13'(bw(hold_box_ff)),
                                 stable_h: 13'(bh(hold_box_ff)),
                                 stable_valid: 1'b1,
                                 fore_area_sum: sum_ff,
                                 boxes_dropped: ovf_ff,
                                 last_result: 1'b0};
                     nsent_ff <= nsent_ff + 1'b1;
                  end
                  if (pend_ff) begin
                     any_ff      <= 1'b1;
                     hold_box_ff <= pend_box_ff;
                  end
                  pend_ff <= 1'b0;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  if (any_ff) begin
                     rsp_ff <= '{stable_x: 12'(bx(hold_box_ff)),
                                 stable_y: 12'(by(hold_box_ff)),
                                 stable_w: 13'(bw(hold_box_ff)),
                                 stable_h: 13'(bh(hold_box_ff)),
                                 stable_valid: 1'b1,
                                 fore_area_sum: sum_ff,
                                 boxes_dropped: ovf_ff,
                                 last_result: 1'b1};
                  end else begin
                     rsp_ff <= '{stable_x: '0,
                                 stable_y: '0,
                                 stable_w: '0,
                                 stable_h: '0,
                                 stable_valid: 1'b0,
                                 fore_area_sum: sum_ff,
                                 boxes_dropped: ovf_ff,
                                 last_result: 1'b1};
                  end
                  nbox_ff <= '0;
                  ovf_ff  <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // The frame buffer count never passes its depth.
   a_nbox_range: assert property (@(posedge clock) disable iff (reset)
      nbox_ff <= BC'(MAX_BOXES)) else $error("frame buffer count overflow");
   // The track count never passes its depth.
   a_ntrk_range: assert property (@(posedge clock) disable iff (reset)
      ntrk_ff <= TC'(MAX_TRACKS)) else $error("track count overflow");
   // No input item is taken while a result other than the frame's last is pending.
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> !req_ready)
      else $error("input accepted mid-frame");
`endif

endmodule

>>> rtl/fbtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbtt_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> verif/tb_foreground_box_track_table_unit.sv
// Self-checking testbench for the foreground box track table unit.
`timescale 1ns / 1ps

module tb_foreground_box_track_table_unit
   import fbtt_pkg::*;
();

   // A remembered or detected box, at the block's field widths.
   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] w;
      logic [12:0] h;
   } box_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   foreground_box_track_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Boxes waiting to be sent, and the stable-track items the block still owes us.
   req_type box_queue[$];
   rsp_type stable_queue[$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   logic    drive_valid;

   function automatic void queue_box(req_type it);
      box_queue = {box_queue, it};
   endfunction

   function automatic void owe_item(rsp_type r);
      stable_queue = {stable_queue, r};
   endfunction

   // Our own copy of the configuration registers, updated at each write.
   logic [24:0] cfg_min_area = 25'd100;
   logic [12:0] cfg_min_side = 13'd15;
   logic [9:0]  cfg_overlap = 10'd950;
   logic [5:0]  cfg_miss_limit = 6'd10;
   logic [5:0]  cfg_retire = 6'd20;
   logic [5:0]  cfg_stable = 6'd40;
   logic [24:0] cfg_stable_area = 25'd250;

   // Our own copy of the track table and the frame buffer.
   box_type trk_box[MaxTracks];
   int      trk_hits[MaxTracks];
   int      trk_misses[MaxTracks];
   int      trk_count = 0;
   box_type frm_box[MaxBoxes];
   bit      frm_claimed[MaxBoxes];
   int      frm_count = 0;
   bit      frm_overflow = 0;

   // Overlap test: intersection times 1000 against the threshold times the
   // area of the bounding box that holds both.
   function automatic bit overlaps(box_type a, box_type b);
      longint unsigned ax1, ay1, bx1, by1, ix0, iy0, ix1, iy1, inter, uw, uh;
      ax1 = a.x + a.w;
      ay1 = a.y + a.h;
      bx1 = b.x + b.w;
      by1 = b.y + b.h;
      ix0 = (a.x > b.x) ? a.x : b.x;
      iy0 = (a.y > b.y) ? a.y : b.y;
      ix1 = (ax1 < bx1) ? ax1 : bx1;
      iy1 = (ay1 < by1) ? ay1 : by1;
      inter = (ix1 > ix0 && iy1 > iy0) ? (ix1 - ix0) * (iy1 - iy0) : 0;
      uw = ((ax1 > bx1) ? ax1 : bx1) - ((a.x < b.x) ? a.x : b.x);
      uh = ((ay1 > by1) ? ay1 : by1) - ((a.y < b.y) ? a.y : b.y);
      return inter * 1000 > cfg_overlap * (uw * uh);
   endfunction

   // Takes one accepted box item. On frame end it updates the track table and
   // queues the stable-track items that the block must send for this frame.
   function automatic void track_frame(req_type it);
      box_type         b;
      longint unsigned sum;
      longint unsigned area;
      int              kept;
      bit              had_tracks;
      bit              matched;
      bit              keep;
      rsp_type         r;
      rsp_type         frame_out[$];
      if (it.box_present) begin
         b = '{it.box_x, it.box_y, it.box_w, it.box_h};
         if (it.contour_area >= cfg_min_area && b.w >= cfg_min_side &&
             b.h >= cfg_min_side) begin
            if (frm_count < MaxBoxes) begin
               frm_box[frm_count] = b;
               frm_claimed[frm_count] = 0;
               frm_count++;
            end else begin
               frm_overflow = 1;
            end
         end
      end
      if (!it.frame_end) return;

      sum = 0;
      for (int i = 0; i < frm_count; i++) begin
         sum += longint'(frm_box[i].w) * frm_box[i].h;
         if (sum > SumMax) sum = SumMax;
         frm_claimed[i] = 0;
      end

      // Walk the table in order; each track claims the first free box that
      // overlaps it, and the table is compacted as tracks are dropped.
      had_tracks = trk_count != 0;
      kept = 0;
      for (int t = 0; t < trk_count; t++) begin
         matched = 0;
         for (int i = 0; i < frm_count && !matched; i++) begin
            if (!frm_claimed[i] && overlaps(trk_box[t], frm_box[i])) begin
               frm_claimed[i] = 1;
               trk_box[t] = frm_box[i];
               if (trk_hits[t] < CountMax) trk_hits[t]++;
               trk_misses[t] = 0;
               matched = 1;
            end
         end
         if (matched) begin
            keep = trk_hits[t] <= cfg_retire;
         end else begin
            if (trk_misses[t] < CountMax) trk_misses[t]++;
            keep = trk_misses[t] <= cfg_miss_limit;
         end
         if (keep) begin
            trk_box[kept] = trk_box[t];
            trk_hits[kept] = trk_hits[t];
            trk_misses[kept] = trk_misses[t];
            kept++;
         end
      end
      trk_count = kept;

      // Unclaimed boxes become new tracks while there is room.
      for (int i = 0; i < frm_count; i++) begin
         if (frm_claimed[i]) continue;
         if (trk_count < MaxTracks) begin
            trk_box[trk_count] = frm_box[i];
            trk_hits[trk_count] = 0;
            trk_misses[trk_count] = 0;
            trk_count++;
         end else begin
            frm_overflow = 1;
         end
      end

      // A table that was empty at frame end emits no stable list.
      if (had_tracks) begin
         for (int t = 0; t < trk_count && frame_out.size() < MaxTracks; t++) begin
            area = longint'(trk_box[t].w) * trk_box[t].h;
            if (trk_hits[t] > cfg_stable && area > cfg_stable_area) begin
               r = '0;
               r.stable_x = trk_box[t].x;
               r.stable_y = trk_box[t].y;
               r.stable_w = trk_box[t].w;
               r.stable_h = trk_box[t].h;
               r.stable_valid = 1'b1;
               r.fore_area_sum = sum[SumBits-1:0];
               r.boxes_dropped = frm_overflow;
               frame_out = {frame_out, r};
            end
         end
      end
      if (frame_out.size() == 0) begin
         r = '0;
         r.fore_area_sum = sum[SumBits-1:0];
         r.boxes_dropped = frm_overflow;
         frame_out = {frame_out, r};
      end
      frame_out[frame_out.size()-1].last_result = 1'b1;
      foreach (frame_out[k]) owe_item(frame_out[k]);

      frm_count = 0;
      frm_overflow = 0;
   endfunction

   // Sender: the valid flag is worked out once per edge and assigned once, so
   // an item that follows straight on keeps valid high without a glitch.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive_valid = req_valid;
         if (req_valid && req_ready) begin
            track_frame(req_data);
            drive_valid = 1'b0;
         end
         if (!drive_valid && box_queue.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_data <= box_queue.pop_front();
            drive_valid = 1'b1;
         end
         req_valid <= drive_valid;
      end
   end

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Receiver: random stalls, and every accepted item is checked against the
   // oldest one still owed.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (stable_queue.size() == 0) begin
               $display("%0t: unexpected item, expected none actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = stable_queue.pop_front();
               check_field("stable_x", want.stable_x, rsp_data.stable_x);
               check_field("stable_y", want.stable_y, rsp_data.stable_y);
               check_field("stable_w", want.stable_w, rsp_data.stable_w);
               check_field("stable_h", want.stable_h, rsp_data.stable_h);
               check_field("stable_valid", want.stable_valid, rsp_data.stable_valid);
               check_field("fore_area_sum", want.fore_area_sum, rsp_data.fore_area_sum);
               check_field("boxes_dropped", want.boxes_dropped, rsp_data.boxes_dropped);
               check_field("last_result", want.last_result, rsp_data.last_result);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic req_type make_item(int x, int y, int w, int h, int area,
                                         bit present, bit fend);
      req_type it;
      it.box_x = 12'(x);
      it.box_y = 12'(y);
      it.box_w = 13'(w);
      it.box_h = 13'(h);
      it.contour_area = 25'(area);
      it.box_present = present;
      it.frame_end = fend;
      return it;
   endfunction

   function automatic req_type noise_item();
      return make_item($urandom_range(4095), $urandom_range(4095), $urandom_range(4096),
                       $urandom_range(4096), $urandom_range(16777216), 1'b1, 1'b0);
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CsrMinArea:   cfg_min_area = value[24:0];
         CsrMinSide:   cfg_min_side = value[12:0];
         CsrOverlap:   cfg_overlap = value[9:0];
         CsrMissLimit: cfg_miss_limit = value[5:0];
         CsrRetire:    cfg_retire = value[5:0];
         CsrStable:    cfg_stable = value[5:0];
         CsrStableMin: cfg_stable_area = value[24:0];
         default: ;
      endcase
   endtask

   task automatic write_all(int min_area, int min_side, int overlap, int miss,
                            int retire, int stable, int stable_area);
      write_reg(CsrMinArea, min_area);
      write_reg(CsrMinSide, min_side);
      write_reg(CsrOverlap, overlap);
      write_reg(CsrMissLimit, miss);
      write_reg(CsrRetire, retire);
      write_reg(CsrStable, stable);
      write_reg(CsrStableMin, stable_area);
   endtask

   // Holds off until every item is sent and every stable item has come back,
   // then gives the block time to finish its table walk. The check runs at
   // the falling edge, once the sender's updates have settled.
   task automatic drain();
      while (box_queue.size() > 0 || req_valid || stable_queue.size() > 0)
         @(negedge clock);
      repeat (64) @(posedge clock);
   endtask

   // A scene of boxes that reappear frame after frame with a little jitter,
   // so tracks build up hits; noise boxes and buffer floods are mixed in.
   box_type scene[6];

   task automatic new_scene();
      foreach (scene[k])
         scene[k] = '{12'($urandom_range(3900)), 12'($urandom_range(3900)),
                      13'($urandom_range(16, 120)), 13'($urandom_range(16, 120))};
   endtask

   task automatic random_frames(int target);
      int      sent;
      int      jit;
      req_type it;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(11) == 0) begin
            // Flood the frame buffer past its capacity.
            repeat (MaxBoxes + 2) begin
               queue_box(make_item($urandom_range(3900), $urandom_range(3900),
                                   $urandom_range(16, 60), $urandom_range(16, 60),
                                   $urandom_range(16777216), 1'b1, 1'b0));
               sent++;
            end
         end else begin
            foreach (scene[k]) begin
               if ($urandom_range(5) == 0) continue;
               jit = $urandom_range(2);
               it = make_item(scene[k].x + jit, scene[k].y + jit, scene[k].w, scene[k].h,
                              scene[k].w * scene[k].h / 2, 1'b1, 1'b0);
               if ($urandom_range(9) == 0) it.contour_area = 25'($urandom_range(16777216));
               queue_box(it);
               sent++;
            end
            if ($urandom_range(3) == 0) begin
               queue_box(noise_item());
               sent++;
            end
         end
         // Frame end rides on the last box or comes as an item of its own.
         if (box_queue.size() > 0 && box_queue[$].box_present && $urandom_range(1)) begin
            box_queue[box_queue.size()-1].frame_end = 1'b1;
         end else begin
            it = noise_item();
            it.box_present = 1'b0;
            it.frame_end = 1'b1;
            queue_box(it);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset configuration.
      queue_box(make_item(0, 0, 0, 0, 0, 1'b0, 1'b1));
      queue_box(make_item(4095, 4095, 4096, 4096, 16777216, 1'b1, 1'b0));
      queue_box(make_item(10, 10, 40, 40, 99, 1'b1, 1'b0));
      queue_box(make_item(10, 10, 14, 40, 500, 1'b1, 1'b0));
      queue_box(make_item(10, 10, 40, 14, 500, 1'b1, 1'b0));
      queue_box(make_item(0, 0, 15, 15, 100, 1'b1, 1'b0));
      queue_box(make_item(100, 100, 50, 50, 2500, 1'b1, 1'b1));
      repeat (2) begin
         queue_box(make_item(4095, 4095, 4096, 4096, 16777216, 1'b1, 1'b0));
         queue_box(make_item(0, 0, 15, 15, 100, 1'b1, 1'b0));
         queue_box(make_item(100, 100, 50, 50, 2500, 1'b1, 1'b0));
         queue_box(make_item(2730, 1365, 4096, 4096, 16777216, 1'b0, 1'b1));
      end
      queue_box(make_item(1365, 2730, 4096, 4096, 16777216, 1'b0, 1'b1));
      drain();

      // Everything passes the filters and any overlap counts as a match; a track is
      // dropped on its first miss and stable as soon as it matches.
      write_all(0, 0, 0, 0, 63, 0, 0);
      send_idle_pct = 72;
      stall_pct = 0;
      new_scene();
      queue_box(make_item(50, 50, 0, 0, 0, 1'b1, 1'b1));
      random_frames(25);
      drain();

      // Moderate settings that let the scene's tracks become stable.
      write_all(50, 4, 500, 3, 63, 2, 100);
      send_idle_pct = 0;
      stall_pct = 72;
      new_scene();
      random_frames(30);
      drain();

      // Nothing can match, almost nothing passes the filters.
      write_all(16777216, 4096, 1000, 63, 0, 63, 16777216);
      send_idle_pct = 28;
      stall_pct = 28;
      queue_box(make_item(0, 0, 4096, 4096, 16777216, 1'b1, 1'b0));
      queue_box(make_item(0, 0, 4096, 4096, 16777216, 1'b1, 1'b1));
      random_frames(15);
      drain();

      // Back to the reset filters with stability within reach.
      write_all(100, 15, 950, 10, 40, 1, 250);
      send_idle_pct = 0;
      stall_pct = 0;
      new_scene();
      random_frames(30);
      drain();

      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
